@@ src/json_string_unescape_utf8_core_defines.svh @@
// Assertion macros shared by the JSON string unescape core.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define JSU_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("jsu assertion failed");
`define JSU_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("jsu assertion failed");
`else
`define JSU_ASSERT(label, prop)
`define JSU_ASSERT_NEXT(label, pre, post)
`endif
`endif

@@ src/jsu_pkg.sv @@
// Types, codes and helper functions of the JSON string unescape core.
`default_nettype none
package jsu_pkg;

    localparam int MaxRes = 4;
    localparam int CntW   = $clog2(MaxRes + 1);
    localparam int IdxW   = $clog2(MaxRes);

    localparam logic [2:0] MODE_PLAIN    = 3'd0;
    localparam logic [2:0] MODE_ESC      = 3'd1;
    localparam logic [2:0] MODE_HEX_HI   = 3'd2;
    localparam logic [2:0] MODE_WANT_BSL = 3'd3;
    localparam logic [2:0] MODE_WANT_U   = 3'd4;
    localparam logic [2:0] MODE_HEX_LO   = 3'd5;

    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_CLOSE = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_CONTROL  = 3'd1;
    localparam logic [2:0] ERR_BAD_ESC  = 3'd2;
    localparam logic [2:0] ERR_BAD_HEX  = 3'd3;
    localparam logic [2:0] ERR_TRUNC_U  = 3'd4;
    localparam logic [2:0] ERR_UNPAIRED = 3'd5;
    localparam logic [2:0] ERR_BAD_LOW  = 3'd6;
    localparam logic [2:0] ERR_UNTERM   = 3'd7;

    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LOWER_B   = 8'h62;
    localparam logic [7:0] CH_LOWER_F   = 8'h66;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;
    localparam logic [7:0] CH_LOWER_U   = 8'h75;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic [1:0] string_status;
        logic [2:0] error_code;
    } res_t;

    typedef struct packed {
        logic [CntW-1:0]    count;
        res_t [MaxRes-1:0]  res;
    } dec_t;

    typedef struct packed {
        logic            free;
        logic [CntW-1:0] remaining;
    } buf_status_t;

    function automatic res_t data_result(input logic [7:0] b);
        res_t r;
        r.out_byte      = b;
        r.out_valid     = 1'b1;
        r.string_status = ST_CONT;
        r.error_code    = ERR_NONE;
        return r;
    endfunction

    function automatic res_t flag_result(input logic [1:0] status, input logic [2:0] code);
        res_t r;
        r.out_byte      = 8'h00;
        r.out_valid     = 1'b0;
        r.string_status = status;
        r.error_code    = code;
        return r;
    endfunction

    // Bit 4 set means the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b0, c[3:0] + 4'd9};
        end
        else begin
            r = 5'h10;
        end
        return r;
    endfunction

    function automatic dec_t utf8_encode(input logic [20:0] cp);
        dec_t d;
        d = '0;
        if (cp[20:7] == '0) begin
            d.count  = CntW'(1);
            d.res[0] = data_result({1'b0, cp[6:0]});
        end
        else if (cp[20:11] == '0) begin
            d.count  = CntW'(2);
            d.res[0] = data_result({3'b110, cp[10:6]});
            d.res[1] = data_result({2'b10, cp[5:0]});
        end
        else if (cp[20:16] == '0) begin
            d.count  = CntW'(3);
            d.res[0] = data_result({4'b1110, cp[15:12]});
            d.res[1] = data_result({2'b10, cp[11:6]});
            d.res[2] = data_result({2'b10, cp[5:0]});
        end
        else begin
            d.count  = CntW'(4);
            d.res[0] = data_result({5'b11110, cp[20:18]});
            d.res[1] = data_result({2'b10, cp[17:12]});
            d.res[2] = data_result({2'b10, cp[11:6]});
            d.res[3] = data_result({2'b10, cp[5:0]});
        end
        return d;
    endfunction

endpackage
`default_nettype wire

@@ src/jsu_in_if.sv @@
// Input channel interface carrying raw string body bytes.
`default_nettype none
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface
`default_nettype wire

@@ src/jsu_out_if.sv @@
// Output channel interface carrying decoded results.
`default_nettype none
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] string_status;
    logic [2:0] error_code;
    logic       last;

    modport source (output valid, output out_byte, output out_valid,
                    output string_status, output error_code, output last, input ready);
    modport sink (input valid, input out_byte, input out_valid,
                  input string_status, input error_code, input last, output ready);
endinterface
`default_nettype wire

@@ src/jsu_decode.sv @@
// Escape decoder: escape state registers and the per-byte result logic.
`default_nettype none
module jsu_decode (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         step,
    input  wire logic [7:0]   in_byte,
    input  wire logic         text_end,
    output jsu_pkg::dec_t     result
);

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  hc_reg, hc_next;
    logic [15:0] first_reg, first_next;
    logic [15:0] second_reg, second_next;

    logic [4:0]  hv;
    logic [15:0] first_sh;
    logic [15:0] second_sh;
    logic [20:0] pair_cp;
    logic        fail_en;
    logic [2:0]  fail_code;
    logic        idle_en;

    assign hv        = jsu_pkg::hex_value(in_byte);
    assign first_sh  = {first_reg[11:0], hv[3:0]};
    assign second_sh = {second_reg[11:0], hv[3:0]};
    assign pair_cp   = jsu_pkg::SUPP_BASE + {1'b0, first_reg[9:0], second_sh[9:0]};

    always_comb
    begin
        mode_next   = mode_reg;
        hc_next     = hc_reg;
        first_next  = first_reg;
        second_next = second_reg;
        result      = '0;
        fail_en     = 1'b0;
        fail_code   = jsu_pkg::ERR_NONE;
        idle_en     = 1'b0;
        if (text_end)
        begin
            fail_en = 1'b1;
            unique case (mode_reg)
                jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: fail_code = jsu_pkg::ERR_TRUNC_U;
                jsu_pkg::MODE_WANT_BSL, jsu_pkg::MODE_WANT_U: fail_code = jsu_pkg::ERR_UNPAIRED;
                default: fail_code = jsu_pkg::ERR_UNTERM;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                jsu_pkg::MODE_ESC:
                begin
                    mode_next    = jsu_pkg::MODE_PLAIN;
                    result.count = jsu_pkg::CntW'(1);
                    unique case (in_byte)
                        jsu_pkg::CH_QUOTE:     result.res[0] = jsu_pkg::data_result(in_byte);
                        jsu_pkg::CH_BACKSLASH: result.res[0] = jsu_pkg::data_result(in_byte);
                        jsu_pkg::CH_SLASH:     result.res[0] = jsu_pkg::data_result(in_byte);
                        jsu_pkg::CH_LOWER_B:   result.res[0] = jsu_pkg::data_result(8'h08);
                        jsu_pkg::CH_LOWER_F:   result.res[0] = jsu_pkg::data_result(8'h0C);
                        jsu_pkg::CH_LOWER_N:   result.res[0] = jsu_pkg::data_result(8'h0A);
                        jsu_pkg::CH_LOWER_R:   result.res[0] = jsu_pkg::data_result(8'h0D);
                        jsu_pkg::CH_LOWER_T:   result.res[0] = jsu_pkg::data_result(8'h09);
                        jsu_pkg::CH_LOWER_U:
                        begin
                            result.count = '0;
                            mode_next    = jsu_pkg::MODE_HEX_HI;
                            hc_next      = 2'd0;
                            first_next   = 16'h0000;
                        end
                        default:
                        begin
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::ERR_BAD_ESC;
                        end
                    endcase
                end
                jsu_pkg::MODE_HEX_HI:
                begin
                    if (hv[4])
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_HEX;
                    end
                    else if (hc_reg != 2'd3)
                    begin
                        first_next = first_sh;
                        hc_next    = hc_reg + 2'd1;
                    end
                    else
                    begin
                        first_next = first_sh;
                        hc_next    = 2'd0;
                        if (first_sh[15:10] == jsu_pkg::HIGH_SURR_TAG)
                        begin
                            mode_next = jsu_pkg::MODE_WANT_BSL;
                        end
                        else if (first_sh[15:10] == jsu_pkg::LOW_SURR_TAG)
                        begin
                            fail_en   = 1'b1;
                            fail_code = jsu_pkg::ERR_UNPAIRED;
                        end
                        else
                        begin
                            result  = jsu_pkg::utf8_encode({5'd0, first_sh});
                            idle_en = 1'b1;
                        end
                    end
                end
                jsu_pkg::MODE_WANT_BSL:
                begin
                    if (in_byte == jsu_pkg::CH_BACKSLASH)
                    begin
                        mode_next = jsu_pkg::MODE_WANT_U;
                    end
                    else
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_UNPAIRED;
                    end
                end
                jsu_pkg::MODE_WANT_U:
                begin
                    if (in_byte == jsu_pkg::CH_LOWER_U)
                    begin
                        mode_next   = jsu_pkg::MODE_HEX_LO;
                        hc_next     = 2'd0;
                        second_next = 16'h0000;
                    end
                    else
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_UNPAIRED;
                    end
                end
                jsu_pkg::MODE_HEX_LO:
                begin
                    if (hv[4])
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_HEX;
                    end
                    else if (hc_reg != 2'd3)
                    begin
                        second_next = second_sh;
                        hc_next     = hc_reg + 2'd1;
                    end
                    else if (second_sh[15:10] != jsu_pkg::LOW_SURR_TAG)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_BAD_LOW;
                    end
                    else
                    begin
                        result  = jsu_pkg::utf8_encode(pair_cp);
                        idle_en = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = jsu_pkg::MODE_PLAIN;
                    if (in_byte == jsu_pkg::CH_QUOTE)
                    begin
                        result.count  = jsu_pkg::CntW'(1);
                        result.res[0] = jsu_pkg::flag_result(jsu_pkg::ST_CLOSE,
                                                             jsu_pkg::ERR_NONE);
                        idle_en       = 1'b1;
                    end
                    else if (in_byte < jsu_pkg::CH_SPACE)
                    begin
                        fail_en   = 1'b1;
                        fail_code = jsu_pkg::ERR_CONTROL;
                    end
                    else if (in_byte == jsu_pkg::CH_BACKSLASH)
                    begin
                        mode_next = jsu_pkg::MODE_ESC;
                    end
                    else
                    begin
                        result.count  = jsu_pkg::CntW'(1);
                        result.res[0] = jsu_pkg::data_result(in_byte);
                    end
                end
            endcase
        end
        if (fail_en)
        begin
            result        = '0;
            result.count  = jsu_pkg::CntW'(1);
            result.res[0] = jsu_pkg::flag_result(jsu_pkg::ST_ERROR, fail_code);
            idle_en       = 1'b1;
        end
        if (idle_en)
        begin
            mode_next   = jsu_pkg::MODE_PLAIN;
            hc_next     = 2'd0;
            first_next  = 16'h0000;
            second_next = 16'h0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jsu_pkg::MODE_PLAIN;
            hc_reg     <= 2'd0;
            first_reg  <= 16'h0000;
            second_reg <= 16'h0000;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            hc_reg     <= hc_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule
`default_nettype wire

@@ src/jsu_out_buf.sv @@
// Result register that holds the results of one byte and hands them out one per transfer.
`default_nettype none
module jsu_out_buf (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire jsu_pkg::dec_t     result,
    output jsu_pkg::buf_status_t   status,
    jsu_out_if.source              result_chan
);

    jsu_pkg::dec_t                 buf_reg;
    logic [jsu_pkg::CntW-1:0]      rem_reg, rem_next;
    logic [jsu_pkg::IdxW-1:0]      idx_reg, idx_next;
    logic                          pop;
    jsu_pkg::res_t                 cur;

    assign cur  = buf_reg.res[idx_reg];
    assign pop  = result_chan.valid && result_chan.ready;

    assign result_chan.valid         = (rem_reg != '0);
    assign result_chan.out_byte      = cur.out_byte;
    assign result_chan.out_valid     = cur.out_valid;
    assign result_chan.string_status = cur.string_status;
    assign result_chan.error_code    = cur.error_code;
    assign result_chan.last          = (rem_reg == jsu_pkg::CntW'(1));

    assign status.free      = (rem_reg == '0) || ((rem_reg == jsu_pkg::CntW'(1)) && pop);
    assign status.remaining = rem_reg;

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = result.count;
            idx_next = '0;
        end
        else if (pop)
        begin
            rem_next = rem_reg - jsu_pkg::CntW'(1);
            idx_next = idx_reg + jsu_pkg::IdxW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            buf_reg <= result;
        end
    end

endmodule
`default_nettype wire

@@ src/json_string_unescape_utf8_core.sv @@
// Top level of the JSON string unescape core: input register, decoder and result register.
`default_nettype none
// The core takes a JSON string body one byte per transfer, starting after the opening
// quote, and returns the unescaped text as UTF-8 bytes, one result per transfer, followed
// by a status result on a closing quote or an error; last marks the final result of each
// input byte. An input byte is registered, decoded from the input register, and its
// zero to four results are written to the result register, which offers them one per
// transfer; the first result is offered once the byte has passed both registers.
// The rate is set by the single result port: a byte holds it until its last result
// transfers, and a byte that yields none (a backslash or a hex digit in the middle of an
// escape) passes without holding it, so plain text runs at one byte per clock while the
// output is not stalled. While results wait on a stalled output, the input register takes
// at most one more byte and then holds the input until the last waiting result transfers.
`include "json_string_unescape_utf8_core_defines.svh"
module json_string_unescape_utf8_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    jsu_in_if.sink     byte_chan,
    jsu_out_if.source  result_chan
);

    logic                  hold_valid_reg, hold_valid_next;
    logic [7:0]            hold_byte_reg;
    logic                  hold_end_reg;
    logic                  take;
    logic                  step;
    jsu_pkg::dec_t         dec;
    jsu_pkg::buf_status_t  buf_status;
    logic                  err_shown;
    logic                  err_flagged;

    assign step            = hold_valid_reg && buf_status.free;
    assign byte_chan.ready = !hold_valid_reg || step;
    assign take            = byte_chan.valid && byte_chan.ready;
    assign hold_valid_next = take || (hold_valid_reg && !step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_byte_reg <= byte_chan.in_byte;
            hold_end_reg  <= byte_chan.text_end;
        end
    end

    jsu_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .in_byte  (hold_byte_reg),
        .text_end (hold_end_reg),
        .result   (dec)
    );

    jsu_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (step),
        .result      (dec),
        .status      (buf_status),
        .result_chan (result_chan)
    );

    assign err_shown   = result_chan.valid
                         && (result_chan.string_status == jsu_pkg::ST_ERROR);
    assign err_flagged = !result_chan.out_valid
                         && (result_chan.error_code != jsu_pkg::ERR_NONE)
                         && result_chan.last;

    `JSU_ASSERT_NEXT(a_held_byte_kept, hold_valid_reg && !step, hold_valid_reg)
    `JSU_ASSERT(a_rem_bounded, buf_status.remaining <= jsu_pkg::CntW'(jsu_pkg::MaxRes))
    `JSU_ASSERT(a_dec_count_bounded, !step || dec.count <= jsu_pkg::CntW'(jsu_pkg::MaxRes))
    `JSU_ASSERT(a_error_has_code, !err_shown || err_flagged)

endmodule
`default_nettype wire
